FILE: rtl/krt_pkg.sv
// krt_pkg: shared types and codes for the keyed record table
// used by krt_ctrl, krt_datapath, krt_checker and the top level
// depends on nothing
package krt_pkg;

	// default table size
	localparam int unsigned KRT_DEPTH = 16;

	// operation codes on the func input
	localparam logic [2:0] FN_INSERT    = 3'd0;
	localparam logic [2:0] FN_UPDATE    = 3'd1;
	localparam logic [2:0] FN_DELETE    = 3'd2;
	localparam logic [2:0] FN_SEARCH    = 3'd3;
	localparam logic [2:0] FN_SORT_ASC  = 3'd4;
	localparam logic [2:0] FN_SORT_DESC = 3'd5;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// one stored record
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] amount;
	} rec_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN,
		OP_INSERT,
		OP_UPDATE,
		OP_DEL_INIT,
		OP_DEL_RD,
		OP_DEL_WR,
		OP_DEL_END,
		OP_SORT_RD1,
		OP_SORT_LDI,
		OP_SORT_SHIFT,
		OP_SORT_PLACE
	} op_t;

	// controller to datapath command
	typedef struct packed {
		op_t     op;
		logic    emit;
		status_t st;
		logic    use_cur;
		logic    last;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] func;
		logic       full;
		logic       fill_lt2;
		logic       hit;
		logic       scan_end;
		logic       have;
		logic       move;
		logic       j_is_one;
		logic       j_next_lt_fill;
		logic       i_next_lt_fill;
	} dp_stat_t;

endpackage

FILE: rtl/krt_datapath.sv
// krt_datapath: record memory, fill count, scan and sort indexes, result registers
// depends on krt_pkg; driven by krt_ctrl through dp_cmd_t
module krt_datapath import krt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = KRT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         func,
	input  logic signed [31:0] key,
	input  logic [31:0]        amount,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               valid,
	output logic [1:0]         status,
	output logic signed [31:0] found_key,
	output logic [31:0]        found_amount,
	output logic [4:0]         entry_count,
	output logic               last
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// record store, one write and one registered read per cycle
	rec_t mem [TABLE_DEPTH];
	rec_t rdata_s1;
	logic pend_s1;
	logic [CW-1:0] idx_s1;

	// request and working registers
	logic [2:0]  req_func_q;
	logic [31:0] req_key_q;
	logic [31:0] req_amt_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	rec_t cur_q;
	logic have_q;

	// result registers
	logic        valid_q;
	status_t     status_q;
	logic [31:0] fkey_q;
	logic [31:0] famt_q;
	logic [4:0]  count_q;
	logic        last_q;

	logic [CW-1:0] fill_d;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] j_inc;
	logic [CW-1:0] i_dec;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] j_dec2;
	logic          i_lt_fill;
	logic          hit;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	rec_t          wr_data;

	assign i_inc     = i_q + 1'b1;
	assign j_inc     = j_q + 1'b1;
	assign i_dec     = i_q - 1'b1;
	assign j_dec     = j_q - 1'b1;
	assign j_dec2    = j_q - CW'(2);
	assign i_lt_fill = i_q < fill_q;
	assign hit       = pend_s1 && (rdata_s1.key == req_key_q);

	// status toward the controller
	always_comb begin
		stat.func           = req_func_q;
		stat.full           = fill_q >= CW'(TABLE_DEPTH);
		stat.fill_lt2       = fill_q < CW'(2);
		stat.hit            = hit;
		stat.scan_end       = !pend_s1 && !i_lt_fill;
		stat.have           = have_q;
		stat.move           = (req_func_q == FN_SORT_DESC) ?
		                      (rdata_s1.amount < cur_q.amount) :
		                      (rdata_s1.amount > cur_q.amount);
		stat.j_is_one       = j_q == CW'(1);
		stat.j_next_lt_fill = j_inc < fill_q;
		stat.i_next_lt_fill = i_inc < fill_q;
	end

	// memory port and fill count selection per operation
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = j_q[IW-1:0];
		wr_data = rdata_s1;
		fill_d  = fill_q;
		case (cmd.op)
			OP_SCAN: begin
				rd_en   = i_lt_fill;
				rd_addr = i_q[IW-1:0];
			end
			OP_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = fill_q[IW-1:0];
				wr_data = '{key: req_key_q, amount: req_amt_q};
				fill_d  = fill_q + 1'b1;
			end
			OP_UPDATE: begin
				wr_en   = 1'b1;
				wr_addr = idx_s1[IW-1:0];
				wr_data = '{key: req_key_q, amount: req_amt_q};
			end
			OP_DEL_RD: begin
				rd_en   = 1'b1;
				rd_addr = j_inc[IW-1:0];
			end
			OP_DEL_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rdata_s1;
			end
			OP_DEL_END: begin
				fill_d = fill_q - 1'b1;
			end
			OP_SORT_RD1: begin
				rd_en   = 1'b1;
				rd_addr = IW'(1);
			end
			OP_SORT_LDI: begin
				rd_en   = 1'b1;
				rd_addr = i_dec[IW-1:0];
			end
			OP_SORT_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rdata_s1;
				rd_en   = 1'b1;
				rd_addr = j_dec2[IW-1:0];
			end
			OP_SORT_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = cur_q;
				rd_en   = 1'b1;
				rd_addr = i_inc[IW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// record memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// request capture and payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_func_q <= func;
			req_key_q  <= key;
			req_amt_q  <= amount;
		end
		if (cmd.op == OP_SCAN) begin
			idx_s1 <= i_q;
			if (hit) begin
				cur_q <= rdata_s1;
			end
		end
		if (cmd.op == OP_SORT_LDI) begin
			cur_q <= rdata_s1;
		end
		if (cmd.emit) begin
			status_q <= cmd.st;
			last_q   <= cmd.last;
			fkey_q   <= cmd.use_cur ? cur_q.key : 32'd0;
			famt_q   <= cmd.use_cur ? cur_q.amount : 32'd0;
			count_q  <= 5'(fill_d);
		end
	end

	// indexes, fill count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pend_s1 <= 1'b0;
			have_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			valid_q <= cmd.emit;
			case (cmd.op)
				OP_LOAD: begin
					i_q     <= '0;
					pend_s1 <= 1'b0;
					have_q  <= 1'b0;
				end
				OP_SCAN: begin
					pend_s1 <= i_lt_fill;
					if (i_lt_fill) begin
						i_q <= i_inc;
					end
					if (hit) begin
						have_q <= 1'b1;
					end
				end
				OP_DEL_INIT:   j_q <= idx_s1;
				OP_DEL_WR:     j_q <= j_inc;
				OP_SORT_RD1:   i_q <= CW'(1);
				OP_SORT_LDI:   j_q <= i_q;
				OP_SORT_SHIFT: j_q <= j_dec;
				OP_SORT_PLACE: i_q <= i_inc;
				default: begin
					pend_s1 <= pend_s1;
				end
			endcase
		end
	end

	assign valid        = valid_q;
	assign status       = status_q;
	assign found_key    = fkey_q;
	assign found_amount = famt_q;
	assign entry_count  = count_q;
	assign last         = last_q;

endmodule

FILE: rtl/krt_ctrl.sv
// krt_ctrl: operation sequencer for the keyed record table
// depends on krt_pkg; commands krt_datapath through dp_cmd_t
module krt_ctrl import krt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DEL_CHK,
		S_DEL_WR,
		S_SORT_LDI,
		S_SORT_CMP,
		S_SORT_FIX
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// next state and command
	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NONE;
		cmd.emit    = 1'b0;
		cmd.st      = ST_OK;
		cmd.use_cur = 1'b0;
		cmd.last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.func)
					FN_INSERT: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.op = OP_INSERT;
						end
						state_d = S_IDLE;
					end
					FN_UPDATE, FN_DELETE, FN_SEARCH: begin
						state_d = S_SCAN;
					end
					FN_SORT_ASC, FN_SORT_DESC: begin
						if (stat.fill_lt2) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end else begin
							cmd.op  = OP_SORT_RD1;
							state_d = S_SORT_LDI;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				case (stat.func)
					FN_SEARCH: begin
						// hold each hit so the final one can carry last
						cmd.op = OP_SCAN;
						if (stat.hit && stat.have) begin
							cmd.emit    = 1'b1;
							cmd.use_cur = 1'b1;
							cmd.last    = 1'b0;
						end else if (stat.scan_end) begin
							cmd.emit    = 1'b1;
							cmd.use_cur = stat.have;
							cmd.st      = stat.have ? ST_OK : ST_NOT_FOUND;
							state_d     = S_IDLE;
						end
					end
					FN_UPDATE, FN_DELETE: begin
						if (stat.hit) begin
							if (stat.func == FN_UPDATE) begin
								cmd.op   = OP_UPDATE;
								cmd.emit = 1'b1;
								state_d  = S_IDLE;
							end else begin
								cmd.op  = OP_DEL_INIT;
								state_d = S_DEL_CHK;
							end
						end else if (stat.scan_end) begin
							cmd.emit = 1'b1;
							cmd.st   = ST_NOT_FOUND;
							state_d  = S_IDLE;
						end else begin
							cmd.op = OP_SCAN;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			// delete: move later records down one slot
			S_DEL_CHK: begin
				if (stat.j_next_lt_fill) begin
					cmd.op  = OP_DEL_RD;
					state_d = S_DEL_WR;
				end else begin
					cmd.op   = OP_DEL_END;
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DEL_WR: begin
				cmd.op  = OP_DEL_WR;
				state_d = S_DEL_CHK;
			end
			// insertion sort: pick up record i, walk it down
			S_SORT_LDI: begin
				cmd.op  = OP_SORT_LDI;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				if (stat.move) begin
					cmd.op  = OP_SORT_SHIFT;
					state_d = stat.j_is_one ? S_SORT_FIX : S_SORT_CMP;
				end else begin
					cmd.op = OP_SORT_PLACE;
					if (stat.i_next_lt_fill) begin
						state_d = S_SORT_LDI;
					end else begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_SORT_FIX: begin
				cmd.op = OP_SORT_PLACE;
				if (stat.i_next_lt_fill) begin
					state_d = S_SORT_LDI;
				end else begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= state_d != S_IDLE;
		end
	end

	assign busy = busy_q;

endmodule

FILE: rtl/keyed_record_table_with_sort_unit.sv
// keyed_record_table_with_sort_unit: top level of the keyed record table
// depends on krt_pkg, krt_ctrl and krt_datapath
//
// usage:
//  - an item (func, key, amount) is taken at a clock edge with start high
//    and busy low; busy rises the cycle after and falls as the last result
//    shows, so the next item can be taken at the edge that ends that result
//  - each result shows on status, found_key, found_amount, entry_count and last
//    for exactly one cycle with valid high; the receiver cannot stall
//  - insert, undefined func, sort of fewer than two records: the result
//    is decided in the dispatch state and shows from the result registers
//  - update, delete, search walk the table one entry per cycle: a search or a
//    miss gives its final result once the walk ends; update and delete stop at
//    the first hit, delete then moves each later record down via S_DEL_CHK, S_DEL_WR
//  - sort is an insertion sort by amount; the memory has one read and one
//    write port: S_SORT_LDI loads each record, S_SORT_CMP shifts passed
//    records up and places it, or S_SORT_FIX places it at the bottom
//  - search gives one result per hit, last set on the final one
//  - reset clears the fill count and control; record contents are not
//    cleared and are only read once written
module keyed_record_table_with_sort_unit import krt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = KRT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [31:0] key,
	input  logic [31:0]        amount,
	output logic               valid,
	output logic [1:0]         status,
	output logic signed [31:0] found_key,
	output logic [31:0]        found_amount,
	output logic [4:0]         entry_count,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	krt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// record memory and result registers
	krt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.func         (func),
		.key          (key),
		.amount       (amount),
		.cmd          (cmd),
		.stat         (stat),
		.valid        (valid),
		.status       (status),
		.found_key    (found_key),
		.found_amount (found_amount),
		.entry_count  (entry_count),
		.last         (last)
	);

endmodule

FILE: rtl/krt_checker.sv
// krt_checker: port-level checks on the keyed record table, bound to the top level
// depends on krt_pkg and keyed_record_table_with_sort_unit
module krt_checker import krt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = KRT_DEPTH
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               valid,
	input logic [1:0]         status,
	input logic signed [31:0] found_key,
	input logic [31:0]        found_amount,
	input logic [4:0]         entry_count,
	input logic               last
);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result without a pending item");

	// a non-final result shows while the item is still in progress
	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final result but block went idle");

	// error results carry no record and end the item
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status != ST_OK) |-> last && (found_key == 32'sd0) &&
		(found_amount == 32'd0))
		else $error("error result carries record data or is not final");

	// full is reported only with a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ST_FULL) |-> entry_count == 5'(TABLE_DEPTH))
		else $error("table full reported with wrong count");

endmodule

bind keyed_record_table_with_sort_unit krt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_krt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.valid        (valid),
	.status       (status),
	.found_key    (found_key),
	.found_amount (found_amount),
	.entry_count  (entry_count),
	.last         (last)
);
